// File: rtl/agcd_pkg.sv
// Shared types, widths and the microcode program of the array GCD engine.
// Used by agcd_seq, agcd_datapath, array_gcd_engine, agcd_checker and the testbench; depends on nothing.
package agcd_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VAL_W     = 31;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int SHIFT_W   = $clog2(VAL_W);
  localparam int PC_W      = 3;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] divisor;
    logic             overflow;
  } result_t;

  // Datapath operation selected by the current control word.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TAKE,
    OP_INIT,
    OP_LOAD,
    OP_STEP,
    OP_MERGE,
    OP_EMIT
  } op_t;

  // Jump condition: when true the sequencer goes to the target step,
  // otherwise to the next step in the program.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_LAST,
    C_IDX_END,
    C_GCD_BUSY,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_last;
    logic idx_end;
    logic gcd_busy;
    logic out_full;
  } status_t;

  localparam logic [PC_W-1:0] S_WAIT  = PC_W'(0);
  localparam logic [PC_W-1:0] S_INIT  = PC_W'(1);
  localparam logic [PC_W-1:0] S_CHECK = PC_W'(2);
  localparam logic [PC_W-1:0] S_LOAD  = PC_W'(3);
  localparam logic [PC_W-1:0] S_STEP  = PC_W'(4);
  localparam logic [PC_W-1:0] S_MERGE = PC_W'(5);
  localparam logic [PC_W-1:0] S_HOLD  = PC_W'(6);
  localparam logic [PC_W-1:0] S_EMIT  = PC_W'(7);

  // The control store. Stepping past the last word wraps to the first.
  function automatic ctrl_word_t microcode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      S_WAIT:  w = '{op: OP_TAKE,  cond: C_NO_LAST,  target: S_WAIT};
      S_INIT:  w = '{op: OP_INIT,  cond: C_NEVER,    target: S_WAIT};
      S_CHECK: w = '{op: OP_NONE,  cond: C_IDX_END,  target: S_HOLD};
      S_LOAD:  w = '{op: OP_LOAD,  cond: C_NEVER,    target: S_WAIT};
      S_STEP:  w = '{op: OP_STEP,  cond: C_GCD_BUSY, target: S_STEP};
      S_MERGE: w = '{op: OP_MERGE, cond: C_ALWAYS,   target: S_CHECK};
      S_HOLD:  w = '{op: OP_NONE,  cond: C_OUT_FULL, target: S_HOLD};
      S_EMIT:  w = '{op: OP_EMIT,  cond: C_ALWAYS,   target: S_WAIT};
      default: w = '{op: OP_NONE,  cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/agcd_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on agcd_pkg for the control word, status and program.
module agcd_seq (
  input  logic                clk,
  input  logic                rst,
  input  agcd_pkg::status_t   status,
  output agcd_pkg::ctrl_word_t word
);

  logic [agcd_pkg::PC_W-1:0] pc;
  logic [agcd_pkg::PC_W-1:0] pc_next;
  logic                      taken;

  assign word = agcd_pkg::microcode(pc);

  always_comb begin
    unique case (word.cond)
      agcd_pkg::C_NEVER:    taken = 1'b0;
      agcd_pkg::C_ALWAYS:   taken = 1'b1;
      agcd_pkg::C_NO_LAST:  taken = !status.in_last;
      agcd_pkg::C_IDX_END:  taken = status.idx_end;
      agcd_pkg::C_GCD_BUSY: taken = status.gcd_busy;
      agcd_pkg::C_OUT_FULL: taken = status.out_full;
      default:              taken = 1'b1;
    endcase
  end

  assign pc_next = taken ? word.target : pc + agcd_pkg::PC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= agcd_pkg::S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: rtl/agcd_datapath.sv
// Datapath: member memory, member counter, binary GCD registers and the
// output register. Each operation is chosen by the sequencer's control word.
// Depends on agcd_pkg.
module agcd_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  agcd_pkg::ctrl_word_t word,
  input  logic                 item_valid,
  input  agcd_pkg::item_t      item,
  output logic                 item_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  output agcd_pkg::result_t    result,
  output agcd_pkg::status_t    status
);

  logic [agcd_pkg::VAL_W-1:0]   mem [agcd_pkg::MAX_ITEMS];
  logic [agcd_pkg::VAL_W-1:0]   rd_data;
  logic [agcd_pkg::CNT_W-1:0]   count;
  logic                         too_many;
  logic [agcd_pkg::CNT_W-1:0]   idx;
  logic [agcd_pkg::VAL_W-1:0]   g;
  logic [agcd_pkg::VAL_W-1:0]   a;
  logic [agcd_pkg::VAL_W-1:0]   b;
  logic [agcd_pkg::SHIFT_W-1:0] k;
  logic                         take;
  logic                         room;
  logic                         busy;

  assign item_stall = (word.op != agcd_pkg::OP_TAKE);
  assign take       = item_valid && !item_stall;
  assign room       = (count < agcd_pkg::CNT_W'(agcd_pkg::MAX_ITEMS));
  assign busy       = (a != '0) && (b != '0);

  assign status.in_last  = take && item.last;
  assign status.idx_end  = (idx == count);
  assign status.gcd_busy = busy;
  assign status.out_full = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (take && room) begin
      mem[count[agcd_pkg::IDX_W-1:0]] <= item.value;
    end
    rd_data <= mem[idx[agcd_pkg::IDX_W-1:0]];
  end

  // Control state: fill count, drop flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      too_many     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (word.op)
        agcd_pkg::OP_TAKE: begin
          if (take) begin
            if (room) begin
              count <= count + agcd_pkg::CNT_W'(1);
            end else begin
              too_many <= 1'b1;
            end
          end
        end
        agcd_pkg::OP_EMIT: begin
          count        <= '0;
          too_many     <= 1'b0;
          result_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Binary GCD: one halving or subtract-and-halve per step, with the
  // common factors of two counted in k and restored at the merge.
  always_ff @(posedge clk) begin
    unique case (word.op)
      agcd_pkg::OP_INIT: begin
        g   <= '0;
        idx <= '0;
      end
      agcd_pkg::OP_LOAD: begin
        a <= g;
        b <= rd_data;
        k <= '0;
      end
      agcd_pkg::OP_STEP: begin
        if (busy) begin
          case ({a[0], b[0]})
            2'b00: begin
              a <= a >> 1;
              b <= b >> 1;
              k <= k + agcd_pkg::SHIFT_W'(1);
            end
            2'b01: a <= a >> 1;
            2'b10: b <= b >> 1;
            default: begin
              if (a >= b) begin
                a <= (a - b) >> 1;
              end else begin
                b <= (b - a) >> 1;
              end
            end
          endcase
        end
      end
      agcd_pkg::OP_MERGE: begin
        g   <= (a | b) << k;
        idx <= idx + agcd_pkg::CNT_W'(1);
      end
      agcd_pkg::OP_EMIT: begin
        result.divisor  <= g;
        result.overflow <= too_many;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/array_gcd_engine.sv
// Top level of the array GCD engine: connects the microcode sequencer and
// the datapath. Depends on agcd_pkg, agcd_seq and agcd_datapath.
//
// Usage: set members arrive on the item channel (valid/stall), one value per
// request, the final member flagged by last. Up to 64 members are stored;
// further members are dropped and flag overflow in the result. The request
// carrying last produces one request on the result channel with the GCD of
// the stored members (zeros do not count, an all-zero set gives 0).
// Timing: members without last are taken one every cycle while the engine waits.
// After last the sequencer runs a binary GCD over the stored members, one
// step per cycle: each member goes through CHECK, LOAD, the STEP loop and
// MERGE; after the last merge come CHECK, HOLD and EMIT, which loads the
// result. The item channel stalls for that whole time; all members share a
// single GCD step unit. The result sits in an output register, so a stalled
// receiver holds it there; a following set can be taken meanwhile, and its
// result waits for the register to empty.
// Reset (rst, synchronous) empties the set, clears overflow and the output.
module array_gcd_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  agcd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output agcd_pkg::result_t result
);

  agcd_pkg::ctrl_word_t word;
  agcd_pkg::status_t    status;

  agcd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .word   (word)
  );

  agcd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .word         (word),
    .item_valid   (item_valid),
    .item         (item),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .status       (status)
  );

endmodule

// File: sim/agcd_checker.sv
// Checker for the array GCD engine: watches both request channels, keeps its
// own copy of the member store and predicts each set's divisor and overflow.
// Depends on agcd_pkg for the request types and the store size.
module agcd_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  agcd_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  agcd_pkg::result_t result,
  output int                mismatches,
  output int                awaited,
  output int                sets_checked,
  output int                overflow_sets
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [agcd_pkg::VAL_W-1:0] members [agcd_pkg::MAX_ITEMS];
  int                         stored;
  logic                       dropped;
  agcd_pkg::result_t          divisor_q [$];
  int                         fail_total;
  int                         checked_total;
  int                         overflow_total;

  function automatic logic [agcd_pkg::VAL_W-1:0] pair_gcd(
      input logic [agcd_pkg::VAL_W-1:0] a,
      input logic [agcd_pkg::VAL_W-1:0] b);
    logic [agcd_pkg::VAL_W-1:0] r;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // gcd(0, x) = x, so starting from zero handles zero members and empty sets.
  function automatic agcd_pkg::result_t set_divisor();
    agcd_pkg::result_t          res;
    logic [agcd_pkg::VAL_W-1:0] g;
    g = '0;
    for (int k = 0; k < stored; k++) begin
      g = pair_gcd(g, members[k]);
    end
    res.divisor  = g;
    res.overflow = dropped;
    return res;
  endfunction

  always @(posedge clk) begin
    agcd_pkg::result_t want;
    if (rst) begin
      stored         = 0;
      dropped        = 1'b0;
      fail_total     = 0;
      checked_total  = 0;
      overflow_total = 0;
      divisor_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (divisor_q.size() == 0) begin
          $display("%0t: unexpected result divisor=%0d overflow=%0b",
                   $time, result.divisor, result.overflow);
          fail_total++;
        end else begin
          want = divisor_q.pop_front();
          checked_total++;
          if (want.overflow) begin
            overflow_total++;
          end
          if (result.divisor !== want.divisor) begin
            $display("%0t: divisor mismatch, expected %0d, actual %0d",
                     $time, want.divisor, result.divisor);
            fail_total++;
          end
          if (result.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %0b, actual %0b",
                     $time, want.overflow, result.overflow);
            fail_total++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        // Once the store is full, later members, the last one included, are lost.
        if (stored < agcd_pkg::MAX_ITEMS) begin
          members[stored] = item.value;
          stored++;
        end else begin
          dropped = 1'b1;
        end
        if (item.last) begin
          divisor_q.push_back(set_divisor());
          stored  = 0;
          dropped = 1'b0;
        end
      end
    end
    mismatches    <= fail_total;
    awaited       <= divisor_q.size();
    sets_checked  <= checked_total;
    overflow_sets <= overflow_total;
  end

endmodule

// File: sim/tb_array_gcd_engine.sv
// Testbench top for array_gcd_engine: drives sets of members with random gaps
// and result stalls, and gives the verdict. Depends on agcd_pkg, the engine
// RTL and agcd_checker, which does all prediction and comparison.
module tb_array_gcd_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [agcd_pkg::VAL_W-1:0] TOP_VALUE  = '1;
  localparam int                         ITEM_GOAL  = 1200;
  localparam int                         DRAIN_WAIT = 200;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  agcd_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  agcd_pkg::result_t result;

  int mismatches;
  int awaited;
  int sets_checked;
  int overflow_sets;
  int members_sent;
  int sets_sent;
  bit steady_set;

  array_gcd_engine u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  agcd_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .sets_checked  (sets_checked),
    .overflow_sets (overflow_sets)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance, or later by a random idle gap.
  task automatic send_member(input logic [agcd_pkg::VAL_W-1:0] v, input logic is_last);
    int pick;
    int gap;
    item       <= '{value: v, last: is_last};
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    members_sent++;
    if (is_last) begin
      sets_sent++;
    end
    pick = $urandom_range(0, 99);
    if (steady_set || pick < 60) begin
      gap = 0;
    end else if (pick < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_pair(input logic [agcd_pkg::VAL_W-1:0] a,
                           input logic [agcd_pkg::VAL_W-1:0] b);
    send_member(a, 1'b0);
    send_member(b, 1'b1);
  endtask

  // One set of random members that share a random factor, which may be 1, with
  // zeros and the top value mixed in.
  task automatic send_random_set(input int len);
    int                         kind;
    int                         pick;
    longint unsigned            factor;
    longint unsigned            m_hi;
    logic [agcd_pkg::VAL_W-1:0] v;
    kind = $urandom_range(0, 3);
    case (kind)
      0: factor = 64'd1;
      1: factor = 64'($urandom_range(2, 1000));
      2: factor = 64'd1 << $urandom_range(0, 30);
      default: factor = 64'($urandom_range(1, int'(TOP_VALUE)));
    endcase
    m_hi       = 64'(TOP_VALUE) / factor;
    steady_set = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        v = '0;
      end else if (pick < 12) begin
        v = TOP_VALUE;
      end else if (factor == 64'd1) begin
        v = agcd_pkg::VAL_W'($urandom());
      end else begin
        v = agcd_pkg::VAL_W'(factor * 64'($urandom_range(1, int'(m_hi))));
      end
      send_member(v, k == len - 1);
    end
    steady_set = 1'b0;
  endtask

  initial begin
    int pick;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    members_sent = 0;
    sets_sent    = 0;
    steady_set   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sets: zeros, extremes, coprime and shared-power cases.
    send_member('0, 1'b1);
    send_member(TOP_VALUE, 1'b1);
    send_member('0, 1'b0);
    send_member('0, 1'b0);
    send_member('0, 1'b1);
    send_pair('0, agcd_pkg::VAL_W'(84));
    send_pair(agcd_pkg::VAL_W'(84), '0);
    send_member(agcd_pkg::VAL_W'(12), 1'b0);
    send_member(agcd_pkg::VAL_W'(18), 1'b0);
    send_member('0, 1'b0);
    send_member(agcd_pkg::VAL_W'(30), 1'b1);
    send_pair(TOP_VALUE, TOP_VALUE - 1);
    send_pair(agcd_pkg::VAL_W'(1) << 30, agcd_pkg::VAL_W'(1) << 20);
    send_pair(agcd_pkg::VAL_W'(1), TOP_VALUE);
    send_pair(TOP_VALUE - 1, TOP_VALUE >> 1);

    // A full store, one member too many and three too many.
    send_random_set(agcd_pkg::MAX_ITEMS);
    send_random_set(agcd_pkg::MAX_ITEMS + 1);
    send_random_set(agcd_pkg::MAX_ITEMS + 3);

    while (members_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        send_random_set($urandom_range(1, 8));
      end else if (pick < 97) begin
        send_random_set($urandom_range(9, 40));
      end else begin
        send_random_set($urandom_range(agcd_pkg::MAX_ITEMS - 4, agcd_pkg::MAX_ITEMS + 8));
      end
    end
    item_valid <= 1'b0;

    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d members in %0d sets; checked %0d divisors, %0d with overflow.",
             members_sent, sets_sent, sets_checked, overflow_sets);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver back-pressure: quiet stretches, short stalls and a few long ones.
  initial begin
    int pick;
    int run;
    logic level;
    result_stall = 1'b0;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        level = 1'b0;
        run   = $urandom_range(1, 20);
      end else if (pick < 90) begin
        level = 1'b1;
        run   = $urandom_range(1, 3);
      end else begin
        level = 1'b1;
        run   = $urandom_range(20, 80);
      end
      repeat (run) begin
        @(negedge clk);
        result_stall <= level;
      end
    end
  end

endmodule
